### src/skt_pkg.sv
// ----------------------------------------------------------------------------
// skt_pkg: shared types and constants for the sorted key table
// Item layouts, action and status codes, sizing of the cell chain.
// ----------------------------------------------------------------------------
package skt_pkg;

  // number of cells in the chain (2 .. 16, bounded by the 4-bit position)
  localparam int DEPTH = 16;

  localparam int KEY_W  = 16;
  localparam int ITEM_W = 8;
  localparam int POS_W  = 4;
  localparam int ACT_W  = 2;
  localparam int STAT_W = 2;
  localparam int OCC_W  = 5;

  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int IDX_W = $clog2(DEPTH);
  localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

  // action codes
  localparam logic [ACT_W-1:0] ACT_INSERT = 2'd0;
  localparam logic [ACT_W-1:0] ACT_READ   = 2'd1;
  localparam logic [ACT_W-1:0] ACT_REMOVE = 2'd2;

  // status codes
  localparam logic [STAT_W-1:0] ST_OK     = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL   = 2'd1;
  localparam logic [STAT_W-1:0] ST_BADPOS = 2'd2;

  typedef struct packed {
    logic [ACT_W-1:0]  action;
    logic [KEY_W-1:0]  key;
    logic [ITEM_W-1:0] item_id;
    logic [POS_W-1:0]  position;
  } in_item_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [KEY_W-1:0]  out_key;
    logic [ITEM_W-1:0] out_item;
    logic [OCC_W-1:0]  occupancy;
  } out_item_t;

  // one stored entry
  typedef struct packed {
    logic [KEY_W-1:0]  key;
    logic [ITEM_W-1:0] item;
  } entry_t;

  // command broadcast to every cell
  typedef struct packed {
    logic              ins;
    logic              rem;
    logic [KEY_W-1:0]  key;
    logic [ITEM_W-1:0] item;
    logic [POS_W-1:0]  pos;
    logic [CNT_W-1:0]  count;
  } cmd_t;

endpackage

### src/skt_cell.sv
// ----------------------------------------------------------------------------
// skt_cell: one slot of the sorted chain
// Holds one entry; on insert it keeps, takes the new entry or takes its left
// neighbor's; on remove at or before it, it takes its right neighbor's.
// ----------------------------------------------------------------------------
module skt_cell (
  input  logic                     clk,
  input  skt_pkg::cmd_t            cmd,
  input  logic [skt_pkg::IDX_W-1:0] idx,
  input  logic                     left_keep,
  input  skt_pkg::entry_t          left_ent,
  input  skt_pkg::entry_t          right_ent,
  output skt_pkg::entry_t          ent,
  output logic                     keep,
  output logic                     hit
);

  skt_pkg::entry_t ent_r;
  skt_pkg::entry_t ent_nxt;
  logic            occupied;
  logic            at_or_after;
  logic [skt_pkg::CMP_W-1:0] idx_x;
  logic [skt_pkg::CMP_W-1:0] pos_x;

  assign idx_x       = skt_pkg::CMP_W'(idx);
  assign pos_x       = skt_pkg::CMP_W'(cmd.pos);
  assign occupied    = idx_x < skt_pkg::CMP_W'(cmd.count);
  assign at_or_after = idx_x >= pos_x;

  // an occupied cell with key not above the new one stays put
  assign keep = occupied && (ent_r.key <= cmd.key);
  assign hit  = idx_x == pos_x;
  assign ent  = ent_r;

  always_comb begin
    ent_nxt = ent_r;
    if (cmd.ins) begin
      if (!keep) begin
        if (left_keep) begin
          ent_nxt.key  = cmd.key;
          ent_nxt.item = cmd.item;
        end else begin
          ent_nxt = left_ent;
        end
      end
    end else if (cmd.rem && at_or_after) begin
      ent_nxt = right_ent;
    end
  end

  always_ff @(posedge clk) begin
    ent_r <= ent_nxt;
  end

endmodule

### src/sorted_key_table.sv
// ----------------------------------------------------------------------------
// sorted_key_table: insertion-sorted key table built as a chain of cells
// Keeps up to DEPTH entries in ascending key order (ties in arrival order);
// insert, read at rank and remove at rank, one action per item.
// ----------------------------------------------------------------------------
//
//  channel   ports                     handshake
//  -------   -----------------------   --------------------------------------
//  input     start, busy, in_item      taken at an edge with start high,
//                                      busy low
//  result    out_valid, out_item       one cycle wide strobe, no back pressure
//
//  an item's result is registered and shows in the cycle after the item is taken
//  every cell compares and shifts in the same cycle, so one item per cycle;
//  busy stays low
//  reset (rst_n low, synchronous) clears the entry count and the result
//  strobe; cell contents are left as they are and are never read unwritten
//  the receiver cannot stall, so nothing is held back on the result side
//
module sorted_key_table (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  skt_pkg::in_item_t  in_item,
  output logic               out_valid,
  output skt_pkg::out_item_t out_item
);

  // entry count
  logic [skt_pkg::CNT_W-1:0] count_r;
  logic [skt_pkg::CNT_W-1:0] count_nxt;

  // result register
  logic               out_valid_r;
  skt_pkg::out_item_t out_r;
  skt_pkg::out_item_t out_nxt;

  // decode
  logic is_ins;
  logic is_rd;
  logic is_rem;
  logic full;
  logic pos_ok;
  skt_pkg::cmd_t cmd;

  // chain wiring
  skt_pkg::entry_t ent_w  [skt_pkg::DEPTH];
  logic            keep_w [skt_pkg::DEPTH];
  logic            hit_w  [skt_pkg::DEPTH];
  skt_pkg::entry_t rd_ent;

  // the chain never needs to hold the requester off
  assign busy = 1'b0;

  assign is_ins = start && (in_item.action == skt_pkg::ACT_INSERT);
  assign is_rd  = start && (in_item.action == skt_pkg::ACT_READ);
  assign is_rem = start && (in_item.action == skt_pkg::ACT_REMOVE);

  assign full   = count_r == skt_pkg::CNT_W'(skt_pkg::DEPTH);
  // rank must be below the count (which never exceeds depth)
  assign pos_ok = skt_pkg::CMP_W'(in_item.position) < skt_pkg::CMP_W'(count_r);

  // broadcast command; ins/rem only fire when the action is legal
  always_comb begin
    cmd.ins   = is_ins && !full;
    cmd.rem   = is_rem && pos_ok;
    cmd.key   = in_item.key;
    cmd.item  = in_item.item_id;
    cmd.pos   = in_item.position;
    cmd.count = count_r;
  end

  // cell chain: left neighbor feeds inserts, right neighbor feeds removes
  for (genvar i = 0; i < skt_pkg::DEPTH; i++) begin : g_cell
    logic            l_keep;
    skt_pkg::entry_t l_ent;
    skt_pkg::entry_t r_ent;

    if (i == 0) begin : g_head
      // head cell: nothing to its left, the new entry lands here unless kept
      assign l_keep = 1'b1;
      assign l_ent  = '0;
    end else begin : g_body
      assign l_keep = keep_w[i-1];
      assign l_ent  = ent_w[i-1];
    end

    if (i == skt_pkg::DEPTH - 1) begin : g_tail
      assign r_ent = '0;
    end else begin : g_mid
      assign r_ent = ent_w[i+1];
    end

    skt_cell u_cell (
      .clk       (clk),
      .cmd       (cmd),
      .idx       (skt_pkg::IDX_W'(i)),
      .left_keep (l_keep),
      .left_ent  (l_ent),
      .right_ent (r_ent),
      .ent       (ent_w[i]),
      .keep      (keep_w[i]),
      .hit       (hit_w[i])
    );
  end

  // read port: exactly one cell matches the rank, or-combine the hits
  always_comb begin
    rd_ent = '0;
    for (int i = 0; i < skt_pkg::DEPTH; i++) begin
      if (hit_w[i]) begin
        rd_ent = rd_ent | ent_w[i];
      end
    end
  end

  always_comb begin
    count_nxt = count_r;
    if (cmd.ins) begin
      count_nxt = count_r + skt_pkg::CNT_W'(1);
    end else if (cmd.rem) begin
      count_nxt = count_r - skt_pkg::CNT_W'(1);
    end
  end

  // result item
  always_comb begin
    out_nxt.status   = skt_pkg::ST_OK;
    out_nxt.out_key  = '0;
    out_nxt.out_item = '0;
    if (is_ins && full) begin
      out_nxt.status = skt_pkg::ST_FULL;
    end else if ((is_rd || is_rem) && !pos_ok) begin
      out_nxt.status = skt_pkg::ST_BADPOS;
    end else if (is_rd || is_rem) begin
      out_nxt.out_key  = rd_ent.key;
      out_nxt.out_item = rd_ent.item;
    end
    out_nxt.occupancy = skt_pkg::OCC_W'(count_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= start;
    end
  end

  // payload, no reset needed
  always_ff @(posedge clk) begin
    if (start) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

  // every accepted item gives exactly one result in the next cycle
  a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
    start |=> out_valid)
    else $error("accepted item gave no result");

  a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
    !start |=> !out_valid)
    else $error("result without an accepted item");

  // count never runs past the chain length
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= skt_pkg::CNT_W'(skt_pkg::DEPTH))
    else $error("entry count beyond depth");

  // a full report only comes with a full table
  a_full_occ: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_item.status == skt_pkg::ST_FULL)
      |-> out_item.occupancy == skt_pkg::OCC_W'(skt_pkg::DEPTH))
    else $error("full status with table not full");

  // the two lowest ranks stay in order
  a_head_sorted: assert property (@(posedge clk) disable iff (!rst_n)
    count_r >= skt_pkg::CNT_W'(2) |-> ent_w[0].key <= ent_w[1].key)
    else $error("chain head out of order");

endmodule
